@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the pursuit steering controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define PSC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define PSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/psc_pkg.sv @@
// Shared types, widths, register codes and angle constants of the steering controller.
package psc_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int SQRT_STEPS        = 17;

   localparam int POS_W   = 16;
   localparam int DIFF_W  = 17;
   localparam int HEAD_W  = 16;
   localparam int CW      = 36;   // CORDIC x/y, 16 guard bits
   localparam int ZW      = 28;   // CORDIC angle, Q.24
   localparam int ERR_W   = 30;   // heading error, Q.24
   localparam int NW      = 34;   // squared distance
   localparam int QW      = 17;   // root
   localparam int RW      = 19;   // root remainder
   localparam int GAIN_W  = 12;
   localparam int STOP_W  = 15;
   localparam int SPEED_W = 15;
   localparam int RATE_W  = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_LINEAR_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ANGULAR_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_DISTANCE = 2'd2;

   localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST   = 12'd128;
   localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RST  = 12'd1024;
   localparam logic [STOP_W-1:0] STOP_DISTANCE_RST = 15'd205;

   localparam logic signed [ZW-1:0]    ANG_HALF_PI = 28'sd26353589;
   localparam logic signed [ERR_W-1:0] ANG_PI      = 30'sd52707179;
   localparam logic signed [ERR_W-1:0] ANG_TWO_PI  = 30'sd105414357;

   typedef struct packed {
      logic signed [CW-1:0]     x;
      logic signed [CW-1:0]     y;
      logic signed [ZW-1:0]     z;
      logic signed [HEAD_W-1:0] head;
      logic [NW-1:0]            n;
      logic [RW-1:0]            rem;
      logic [QW-1:0]            root;
      logic                     moving;
   } lane_type;

   // Rounded Q.24 arctangent of 2^-idx.
   function automatic logic signed [ZW-1:0] atan_entry(input int idx);
      logic signed [ZW-1:0] v;
      case (idx)
         0:  v = 28'sd13176795;
         1:  v = 28'sd7778716;
         2:  v = 28'sd4110060;
         3:  v = 28'sd2086331;
         4:  v = 28'sd1047214;
         5:  v = 28'sd524117;
         6:  v = 28'sd262123;
         7:  v = 28'sd131069;
         8:  v = 28'sd65536;
         9:  v = 28'sd32768;
         10: v = 28'sd16384;
         11: v = 28'sd8192;
         12: v = 28'sd4096;
         13: v = 28'sd2048;
         14: v = 28'sd1024;
         15: v = 28'sd512;
         16: v = 28'sd256;
         17: v = 28'sd128;
         18: v = 28'sd64;
         19: v = 28'sd32;
         20: v = 28'sd16;
         21: v = 28'sd8;
         22: v = 28'sd4;
         23: v = 28'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/psc_cell.sv @@
// One cell of the chain: a CORDIC vectoring step and a root digit step, registered.
module psc_cell
   import psc_pkg::*;
#(
   parameter int IDX           = 0,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     up_valid,
   input  lane_type up_lane,
   output logic     dn_valid,
   output lane_type dn_lane
);

   logic signed [CW-1:0] x_nx;
   logic signed [CW-1:0] y_nx;
   logic signed [ZW-1:0] z_nx;
   logic [RW-1:0]        rem_nx;
   logic [QW-1:0]        root_nx;
   logic                 valid_ff;
   lane_type             lane_ff;
   lane_type             lane_in;

   generate
      if (IDX < CORDIC_STAGES) begin : g_rot
         localparam logic signed [ZW-1:0] ATAN = atan_entry(IDX);
         logic signed [CW-1:0] x_sh;
         logic signed [CW-1:0] y_sh;
         always_comb begin
            x_sh = up_lane.x >>> IDX;
            y_sh = up_lane.y >>> IDX;
            if (!up_lane.y[CW-1]) begin
               x_nx = up_lane.x + y_sh;
               y_nx = up_lane.y - x_sh;
               z_nx = up_lane.z + ATAN;
            end else begin
               x_nx = up_lane.x - y_sh;
               y_nx = up_lane.y + x_sh;
               z_nx = up_lane.z - ATAN;
            end
         end
      end else begin : g_rot_pass
         assign x_nx = up_lane.x;
         assign y_nx = up_lane.y;
         assign z_nx = up_lane.z;
      end

      if (IDX < SQRT_STEPS) begin : g_root
         logic [RW+1:0] rem_sh;
         logic [RW+1:0] trial;
         always_comb begin
            rem_sh = {up_lane.rem, up_lane.n[NW-1-2*IDX -: 2]};
            trial  = {{(RW-QW){1'b0}}, up_lane.root, 2'b01};
            if (rem_sh >= trial) begin
               rem_nx  = RW'(rem_sh - trial);
               root_nx = {up_lane.root[QW-2:0], 1'b1};
            end else begin
               rem_nx  = RW'(rem_sh);
               root_nx = {up_lane.root[QW-2:0], 1'b0};
            end
         end
      end else begin : g_root_pass
         assign rem_nx  = up_lane.rem;
         assign root_nx = up_lane.root;
      end
   endgenerate

   always_comb begin
      lane_in      = up_lane;
      lane_in.x    = x_nx;
      lane_in.y    = y_nx;
      lane_in.z    = z_nx;
      lane_in.rem  = rem_nx;
      lane_in.root = root_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_lane  = lane_ff;

endmodule

@@ sv/pursuit_steering_controller_core.sv @@
// Top level of the pursuit steering controller: front end, cell chain, gain and output stages.
// A request passes stages 1 to 3, the cell chain, stages E and P and the output register to rsp_valid.
// Throughput: one item per cycle; the whole pipeline moves together and halts only while
// a result sits in the output register with rsp_stall high.
// The chain length is set by the longer of the CORDIC rotation and the 17-digit root.
// Reset (synchronous, active high) empties the pipeline, loads default gains and stop distance.
`include "assert_macros.svh"

module pursuit_steering_controller_core
   import psc_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [POS_W-1:0]  req_target_x,
   input  logic signed [POS_W-1:0]  req_target_y,
   input  logic signed [POS_W-1:0]  req_self_x,
   input  logic signed [POS_W-1:0]  req_self_y,
   input  logic signed [HEAD_W-1:0] req_self_heading,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [SPEED_W-1:0]       rsp_forward_speed,
   output logic signed [RATE_W-1:0] rsp_turn_rate,
   output logic                     rsp_moving,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [STOP_W-1:0]        csr_wdata
);

   localparam int LEN = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
   localparam int FWD_W  = GAIN_W + QW;         // gain * root
   localparam int TRP_W  = GAIN_W + 1 + ERR_W;  // gain * error, signed
   localparam int FSH_W  = FWD_W - 8;
   localparam int TSH_W  = TRP_W - 21;
   localparam logic [FSH_W-1:0]        FWD_MAX = FSH_W'(32767);
   localparam logic signed [TSH_W-1:0] TR_MAX  = TSH_W'(32767);
   localparam logic signed [TSH_W-1:0] TR_MIN  = -TSH_W'(32768);

   // ---------------------------------------------------------------- flow control
   // Every stage shares one advance enable; rsp_stall reaches it combinationally, so a held
   // result freezes the whole pipeline, output register included, and raises req_stall.
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // ---------------------------------------------------------------- registers
   logic [GAIN_W-1:0]   linear_gain_ff;
   logic [GAIN_W-1:0]   angular_gain_ff;
   logic [STOP_W-1:0]   stop_distance_ff;
   logic [2*STOP_W-1:0] stop_sq_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         linear_gain_ff   <= LINEAR_GAIN_RST;
         angular_gain_ff  <= ANGULAR_GAIN_RST;
         stop_distance_ff <= STOP_DISTANCE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LINEAR_GAIN:   linear_gain_ff   <= csr_wdata[GAIN_W-1:0];
            REG_ANGULAR_GAIN:  angular_gain_ff  <= csr_wdata[GAIN_W-1:0];
            REG_STOP_DISTANCE: stop_distance_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Squared threshold, refreshed each cycle; users must change config only while idle (unchecked).
   always_ff @(posedge clock) begin
      stop_sq_ff <= stop_distance_ff * stop_distance_ff;
   end

   // ---------------------------------------------------------------- stage 1: offsets
   logic                     v1_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic signed [HEAD_W-1:0] head1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff    <= DIFF_W'(req_target_x) - DIFF_W'(req_self_x);
         dy_ff    <= DIFF_W'(req_target_y) - DIFF_W'(req_self_y);
         head1_ff <= req_self_heading;
      end
   end

   // ---------------------------------------------------------------- stage 2: squares, pre-rotation
   logic                       v2_ff;
   logic [NW-1:0]              sqx_ff, sqy_ff;
   logic signed [CW-1:0]       x2_ff, y2_ff;
   logic signed [ZW-1:0]       z2_ff;
   logic signed [HEAD_W-1:0]   head2_ff;
   logic signed [2*DIFF_W-1:0] prod_x, prod_y;
   logic signed [CW-1:0]       dx_w, dy_w;
   logic signed [CW-1:0]       x2_in, y2_in;
   logic signed [ZW-1:0]       z2_in;

   assign prod_x = dx_ff * dx_ff;
   assign prod_y = dy_ff * dy_ff;
   assign dx_w   = CW'(dx_ff) <<< 16;
   assign dy_w   = CW'(dy_ff) <<< 16;

   // Quarter-turn pre-rotation puts the vector in the right half plane.
   always_comb begin
      if (!dy_ff[DIFF_W-1]) begin
         x2_in = dy_w;
         y2_in = -dx_w;
         z2_in = ANG_HALF_PI;
      end else begin
         x2_in = -dy_w;
         y2_in = dx_w;
         z2_in = -ANG_HALF_PI;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff   <= prod_x;
         sqy_ff   <= prod_y;
         x2_ff    <= x2_in;
         y2_ff    <= y2_in;
         z2_ff    <= z2_in;
         head2_ff <= head1_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3: distance^2, stop test
   logic          v3_ff;
   lane_type      lane0_ff;
   lane_type      lane0_in;
   logic [NW-1:0] dist_sq;

   assign dist_sq = sqx_ff + sqy_ff;

   always_comb begin
      lane0_in.x      = x2_ff;
      lane0_in.y      = y2_ff;
      lane0_in.z      = z2_ff;
      lane0_in.head   = head2_ff;
      lane0_in.n      = dist_sq;
      lane0_in.rem    = '0;
      lane0_in.root   = '0;
      lane0_in.moving = dist_sq > NW'(stop_sq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane0_ff <= lane0_in;
      end
   end

   // ---------------------------------------------------------------- cell chain
   // Cell k does CORDIC micro-rotation k (k < CORDIC_STAGES) and root digit k (k < 17).
   logic [LEN:0] chain_valid;
   lane_type     chain_lane [LEN+1];

   assign chain_valid[0] = v3_ff;
   assign chain_lane[0]  = lane0_ff;

   generate
      for (genvar k = 0; k < LEN; k++) begin : g_cell
         psc_cell #(
            .IDX           (k),
            .CORDIC_STAGES (CORDIC_STAGES)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (adv),
            .up_valid (chain_valid[k]),
            .up_lane  (chain_lane[k]),
            .dn_valid (chain_valid[k+1]),
            .dn_lane  (chain_lane[k+1])
         );
      end
   endgenerate

   // ---------------------------------------------------------------- stage E: heading error, wrap
   lane_type                 lane_end;
   logic                     ve_ff;
   logic signed [ERR_W-1:0]  e_ff;
   logic [QW-1:0]            root_e_ff;
   logic                     moving_e_ff;
   logic signed [ERR_W-1:0]  e_raw, e_wrap;

   assign lane_end = chain_lane[LEN];
   assign e_raw    = ERR_W'(lane_end.z) - (ERR_W'(lane_end.head) <<< 11);

   // Single wrap; exactly +/-PI stays put.
   always_comb begin
      if (e_raw > ANG_PI) begin
         e_wrap = e_raw - ANG_TWO_PI;
      end else if (e_raw < -ANG_PI) begin
         e_wrap = e_raw + ANG_TWO_PI;
      end else begin
         e_wrap = e_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (adv) begin
         ve_ff <= chain_valid[LEN];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff        <= e_wrap;
         root_e_ff   <= lane_end.root;
         moving_e_ff <= lane_end.moving;
      end
   end

   // ---------------------------------------------------------------- stage P: gain products
   logic                    vp_ff;
   logic [FWD_W-1:0]        fwd_prod_ff;
   logic signed [TRP_W-1:0] tr_prod_ff;
   logic                    moving_p_ff;
   logic signed [GAIN_W:0]  ang_gain_s;

   assign ang_gain_s = {1'b0, angular_gain_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else if (adv) begin
         vp_ff <= ve_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_prod_ff <= linear_gain_ff * root_e_ff;
         tr_prod_ff  <= ang_gain_s * e_ff;
         moving_p_ff <= moving_e_ff;
      end
   end

   // ---------------------------------------------------------------- output register
   logic                     rsp_valid_ff;
   logic [SPEED_W-1:0]       fwd_ff, fwd_in;
   logic signed [RATE_W-1:0] rate_ff, rate_in;
   logic                     moving_ff;
   logic [FSH_W-1:0]         fwd_sh;
   logic signed [TSH_W-1:0]  tr_sh;

   assign fwd_sh = fwd_prod_ff[FWD_W-1:8];
   assign tr_sh  = tr_prod_ff[TRP_W-1:21];   // floor shift

   always_comb begin
      if (!moving_p_ff) begin
         fwd_in  = '0;
         rate_in = '0;
      end else begin
         fwd_in = (fwd_sh > FWD_MAX) ? SPEED_W'(FWD_MAX) : fwd_sh[SPEED_W-1:0];
         if (tr_sh > TR_MAX) begin
            rate_in = RATE_W'(TR_MAX);
         end else if (tr_sh < TR_MIN) begin
            rate_in = RATE_W'(TR_MIN);
         end else begin
            rate_in = tr_sh[RATE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_ff    <= fwd_in;
         rate_ff   <= rate_in;
         moving_ff <= moving_p_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_forward_speed = fwd_ff;
   assign rsp_turn_rate     = rate_ff;
   assign rsp_moving        = moving_ff;

   // ---------------------------------------------------------------- checks
   logic rsp_zero;
   logic e_in_range;

   assign rsp_zero   = (rsp_forward_speed == '0) && (rsp_turn_rate == '0);
   assign e_in_range = (e_ff <= ANG_PI) && (e_ff >= -ANG_PI);

   `PSC_ASSERT_IMPL(a_stop_zero, rsp_valid && !rsp_moving, rsp_zero, "speed while stopped")
   `PSC_ASSERT_IMPL(a_err_wrapped, ve_ff, e_in_range, "heading error outside [-pi, pi]")
   `PSC_ASSERT_NEXT(a_chain_hold, !adv, $stable(chain_valid), "chain moved under stall")

endmodule
